>>> design/bdd_pkg.sv
// Shared types, constants and helper functions for the backward difference
// derivative unit. No dependencies; imported by every module of the block.
package bdd_pkg;

    localparam int CHANNELS    = 8;
    localparam int MAX_ORDER   = 6;
    localparam int WIN_LEN     = MAX_ORDER + 1;
    localparam int DATA_W      = 32;
    localparam int CH_W        = 3;
    localparam int ORDER_W     = 3;
    localparam int CH_IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int TAP_W       = $clog2(WIN_LEN);
    localparam int ROW_W       = WIN_LEN * DATA_W;
    localparam int COEF_W      = 10;
    localparam int PROD_W      = DATA_W + COEF_W;
    localparam int ACC_W       = 44;
    localparam int MAG_W       = 43;
    localparam int PLO_W       = 64;
    localparam int PHI_W       = (MAG_W - 32) + 32;
    localparam int Y_W         = 60;
    localparam int REM_W       = 8;
    localparam int QBITS       = 32;
    localparam int DIV_SHIFT   = 5;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);
    localparam int PADDR_W     = 3;

    // coefficients scaled by 60; result = sum * inv_period / (60 * 2^16)
    localparam logic [REM_W-1:0]   DIV_CONST  = 8'd60;
    localparam logic [REM_W-1:0]   DIV_CONST2 = 8'd120;
    localparam logic [REM_W-1:0]   REM_LIMIT  = 8'd180;
    // floor(2^35 / 15): ((y >> 5) * RECIP_60) >> 32 is at most two below y / 60
    localparam logic [QBITS-1:0]   RECIP_60   = 32'd2290649224;
    localparam logic [PLO_W:0]     ROUND_BIAS = 65'd1966080;
    localparam logic [Y_W-1:0]     Y_LIMIT    = 60'd128849018940;
    localparam logic [DATA_W-1:0]  POS_SAT    = 32'h7fff_ffff;
    localparam logic [DATA_W-1:0]  NEG_SAT    = 32'h8000_0000;
    localparam logic [31:0]        INV_RESET  = 32'd65536;
    localparam logic [ORDER_W-1:0] ORDER_RESET = 3'd1;

    localparam logic REG_DIFF_ORDER = 1'b0;
    localparam logic REG_INV_PERIOD = 1'b1;

    localparam logic signed [COEF_W-1:0] COEF_TAB [6][7] = '{
        '{ 10'sd60,  -10'sd60,    10'sd0,    10'sd0,   10'sd0,   10'sd0,  10'sd0},
        '{ 10'sd90,  -10'sd120,   10'sd30,   10'sd0,   10'sd0,   10'sd0,  10'sd0},
        '{ 10'sd110, -10'sd180,   10'sd90,  -10'sd20,  10'sd0,   10'sd0,  10'sd0},
        '{ 10'sd125, -10'sd240,   10'sd180, -10'sd80,  10'sd15,  10'sd0,  10'sd0},
        '{ 10'sd137, -10'sd300,   10'sd300, -10'sd200, 10'sd75, -10'sd12, 10'sd0},
        '{ 10'sd147, -10'sd360,   10'sd450, -10'sd400, 10'sd225, -10'sd72, 10'sd10}
    };

    typedef struct packed {
        logic [CH_W-1:0]   channel;
        logic [DATA_W-1:0] sample;
        logic              in_range;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } q_head_t;

    typedef struct packed {
        logic [ORDER_W-1:0] order;
        logic [31:0]        inv_period;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_LOAD,
        ST_MAC,
        ST_ABS,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_SUM,
        ST_CHK,
        ST_DIV,
        ST_REM,
        ST_FIX,
        ST_FIN,
        ST_DONE
    } back_state_t;

    function automatic logic [ORDER_W-1:0] order_clamp(input logic [ORDER_W-1:0] raw);
        logic [ORDER_W-1:0] ord;
        ord = raw;
        if (raw == '0) ord = ORDER_W'(1);
        if (int'(raw) > MAX_ORDER) ord = ORDER_W'(MAX_ORDER);
        return ord;
    endfunction

    function automatic logic signed [COEF_W-1:0] coef(input logic [ORDER_W-1:0] ord,
                                                      input logic [TAP_W-1:0] tap);
        logic [ORDER_W-1:0] row;
        row = ord - 1'b1;
        return COEF_TAB[row][tap];
    endfunction

endpackage

>>> design/backward_difference_derivative_unit.sv
// Top level of the backward difference derivative unit: APB register file and
// the front/back split. Depends on bdd_pkg, bdd_front and bdd_back.
//
// Input channel (s_valid/s_ready, s_channel, s_sample_value) takes one Q16.16
// sample per transfer; the result channel (m_valid/m_ready) returns one
// transfer per input, in order: m_channel_out, m_derivative, m_clipped.
// diff_order (0x0) and inv_period (0x4) are written over APB; the user must
// write them only while idle, which the block itself does not enforce. Each
// in-range item passes, for every order, through: queue head check, window
// read and write-back, one MAC tap per cycle over all seven taps, abs, two
// partial products, rounding sum, range check, then a reciprocal multiply by
// 1/60 with a remainder fix-up and the final sign. Results that saturate at
// the range check skip the division; out-of-range channels skip all steps.
// Items are worked one at a time. A two-entry queue accepts new samples while
// the back end is busy, and an output register holds a result while the
// receiver stalls; the back end waits on it, the queue fills, s_ready drops.
// Reset is synchronous, active low: windows read as zero, diff_order = 1,
// inv_period = 1.0 Hz in Q16.16.
module backward_difference_derivative_unit import bdd_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [CH_W-1:0]    s_channel,
    input  logic [DATA_W-1:0]  s_sample_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [CH_W-1:0]    m_channel_out,
    output logic [DATA_W-1:0]  m_derivative,
    output logic               m_clipped,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [ORDER_W-1:0] diff_order_reg, diff_order_next;
    logic [31:0]        inv_period_reg, inv_period_next;
    logic               cfg_we;
    logic               reg_sel;
    cfg_t               cfg;
    q_head_t            head;
    logic               pop;

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite && pready;
    assign reg_sel = paddr[2];

    always_comb begin
        diff_order_next = diff_order_reg;
        inv_period_next = inv_period_reg;
        if (cfg_we) begin
            case (reg_sel)
                REG_DIFF_ORDER: diff_order_next = pwdata[ORDER_W-1:0];
                REG_INV_PERIOD: inv_period_next = pwdata;
                default: begin
                    diff_order_next = diff_order_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            diff_order_reg <= ORDER_RESET;
            inv_period_reg <= INV_RESET;
        end else begin
            diff_order_reg <= diff_order_next;
            inv_period_reg <= inv_period_next;
        end
    end

    always_comb begin
        case (reg_sel)
            REG_DIFF_ORDER: prdata = {{(32-ORDER_W){1'b0}}, diff_order_reg};
            REG_INV_PERIOD: prdata = inv_period_reg;
            default:        prdata = '0;
        endcase
    end

    always_comb begin
        cfg.order      = diff_order_reg;
        cfg.inv_period = inv_period_reg;
    end

    bdd_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_channel      (s_channel),
        .s_sample_value (s_sample_value),
        .pop            (pop),
        .head           (head)
    );

    bdd_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg),
        .head          (head),
        .pop           (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_channel_out (m_channel_out),
        .m_derivative  (m_derivative),
        .m_clipped     (m_clipped)
    );

endmodule

>>> design/bdd_front.sv
// Front end: accepts input transfers, marks out-of-range channels and holds
// them in a two-entry queue for the back end. Depends on bdd_pkg.
module bdd_front import bdd_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [CH_W-1:0]   s_channel,
    input  logic [DATA_W-1:0] s_sample_value,
    input  logic              pop,
    output q_head_t           head
);

    item_t                 qmem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [QCNT_BITS-1:0]  count_reg, count_next;
    logic                  push;
    item_t                 in_item;

    assign s_ready = (count_reg != QCNT_BITS'(QUEUE_DEPTH));
    assign push    = s_valid && s_ready;

    always_comb begin
        in_item.channel  = s_channel;
        in_item.sample   = s_sample_value;
        in_item.in_range = (int'(s_channel) < CHANNELS);
    end

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) count_next = count_reg + 1'b1;
        if (pop && !push) count_next = count_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            qmem_reg[wr_ptr_reg] <= in_item;
        end
    end

    always_comb begin
        head.valid = (count_reg != '0);
        head.item  = qmem_reg[rd_ptr_reg];
    end

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> (count_reg != '0))
        else $error("queue popped while empty");

endmodule

>>> design/bdd_back.sv
// Back end: per-channel window memory, seven-tap MAC, scaling by inv_period,
// reciprocal division by 60, saturation and the output register. Uses bdd_pkg.
module bdd_back import bdd_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  cfg_t              cfg,
    input  q_head_t           head,
    output logic              pop,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [CH_W-1:0]   m_channel_out,
    output logic [DATA_W-1:0] m_derivative,
    output logic              m_clipped
);

    logic [ROW_W-1:0]    win_mem [CHANNELS];
    logic                row_valid_reg [CHANNELS];
    logic [ROW_W-1:0]    rd_row_q;
    logic                rd_vld_q;
    logic [CH_IDX_W-1:0] row_idx;
    logic                mem_we;
    logic [ROW_W-1:0]    new_row;

    back_state_t             state_reg, state_next;
    logic [DATA_W-1:0]       win_reg [WIN_LEN];
    logic [DATA_W-1:0]       win_next [WIN_LEN];
    logic [TAP_W-1:0]        tap_reg, tap_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic                    neg_reg, neg_next;
    logic [MAG_W-1:0]        mag_reg, mag_next;
    logic [PLO_W-1:0]        plo_reg, plo_next;
    logic [PHI_W-1:0]        phi_reg, phi_next;
    logic [Y_W-1:0]          y_reg, y_next;
    logic [REM_W-1:0]        rem_reg, rem_next;
    logic [QBITS-1:0]        q_reg, q_next;
    logic [CH_W-1:0]         ch_reg, ch_next;
    logic [DATA_W-1:0]       res_der_reg, res_der_next;
    logic                    res_clip_reg, res_clip_next;

    logic                    m_valid_reg, m_valid_next;
    logic [CH_W-1:0]         m_channel_out_reg;
    logic [DATA_W-1:0]       m_derivative_reg;
    logic                    m_clipped_reg;
    logic                    out_load;

    logic [ORDER_W-1:0]      ord;
    logic signed [PROD_W-1:0] prod;
    logic [PLO_W:0]          plo_biased;
    logic [2*QBITS-1:0]      recip_prod;
    logic [Y_W-1:0]          q_x60;

    assign row_idx = CH_IDX_W'(head.item.channel);
    assign ord     = order_clamp(cfg.order);
    assign prod    = $signed(win_reg[0]) * coef(ord, tap_reg);
    assign plo_biased = {1'b0, plo_reg} + ROUND_BIAS;
    assign recip_prod = y_reg[DIV_SHIFT +: QBITS] * RECIP_60;
    // 60q = 64q - 4q
    assign q_x60      = (Y_W'(q_reg) << 6) - (Y_W'(q_reg) << 2);

    always_comb begin
        for (int k = 0; k < WIN_LEN; k++) begin
            if (k == 0) begin
                new_row[k*DATA_W +: DATA_W] = head.item.sample;
            end else begin
                new_row[k*DATA_W +: DATA_W] =
                    rd_vld_q ? rd_row_q[(k-1)*DATA_W +: DATA_W] : '0;
            end
        end
    end

    always_comb begin
        state_next    = state_reg;
        tap_next      = tap_reg;
        acc_next      = acc_reg;
        neg_next      = neg_reg;
        mag_next      = mag_reg;
        plo_next      = plo_reg;
        phi_next      = phi_reg;
        y_next        = y_reg;
        rem_next      = rem_reg;
        q_next        = q_reg;
        ch_next       = ch_reg;
        res_der_next  = res_der_reg;
        res_clip_next = res_clip_reg;
        for (int k = 0; k < WIN_LEN; k++) win_next[k] = win_reg[k];
        pop      = 1'b0;
        mem_we   = 1'b0;
        out_load = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (head.valid) begin
                    if (head.item.in_range) begin
                        state_next = ST_READ;
                    end else begin
                        pop           = 1'b1;
                        ch_next       = head.item.channel;
                        res_der_next  = '0;
                        res_clip_next = 1'b0;
                        state_next    = ST_DONE;
                    end
                end
            end
            ST_READ: begin
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                mem_we  = 1'b1;
                pop     = 1'b1;
                ch_next = head.item.channel;
                for (int k = 0; k < WIN_LEN; k++) win_next[k] = new_row[k*DATA_W +: DATA_W];
                acc_next   = '0;
                tap_next   = '0;
                state_next = ST_MAC;
            end
            ST_MAC: begin
                acc_next = acc_reg + ACC_W'(prod);
                for (int k = 0; k < WIN_LEN - 1; k++) win_next[k] = win_reg[k+1];
                tap_next = tap_reg + 1'b1;
                if (tap_reg == TAP_W'(WIN_LEN - 1)) begin
                    state_next = ST_ABS;
                end
            end
            ST_ABS: begin
                neg_next   = acc_reg[ACC_W-1];
                mag_next   = acc_reg[ACC_W-1] ? MAG_W'(-acc_reg) : MAG_W'(acc_reg);
                state_next = ST_MUL_LO;
            end
            ST_MUL_LO: begin
                plo_next   = PLO_W'(mag_reg[31:0] * cfg.inv_period);
                state_next = ST_MUL_HI;
            end
            ST_MUL_HI: begin
                phi_next   = PHI_W'(mag_reg[MAG_W-1:32] * cfg.inv_period);
                state_next = ST_SUM;
            end
            ST_SUM: begin
                y_next     = (Y_W'(phi_reg) << 16) + Y_W'(plo_biased >> 16);
                state_next = ST_CHK;
            end
            ST_CHK: begin
                if (y_reg >= Y_LIMIT) begin
                    res_der_next  = neg_reg ? NEG_SAT : POS_SAT;
                    res_clip_next = 1'b1;
                    state_next    = ST_DONE;
                end else begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                q_next     = recip_prod[2*QBITS-1:QBITS];
                state_next = ST_REM;
            end
            ST_REM: begin
                rem_next   = REM_W'(y_reg - q_x60);
                state_next = ST_FIX;
            end
            ST_FIX: begin
                if (rem_reg >= DIV_CONST2) begin
                    q_next = q_reg + QBITS'(2);
                end else if (rem_reg >= DIV_CONST) begin
                    q_next = q_reg + QBITS'(1);
                end
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (neg_reg) begin
                    res_der_next  = DATA_W'(-q_reg);
                    res_clip_next = 1'b0;
                end else if (q_reg[QBITS-1]) begin
                    res_der_next  = POS_SAT;
                    res_clip_next = 1'b1;
                end else begin
                    res_der_next  = DATA_W'(q_reg);
                    res_clip_next = 1'b0;
                end
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) m_valid_next = 1'b0;
        if (out_load)               m_valid_next = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        tap_reg      <= tap_next;
        acc_reg      <= acc_next;
        neg_reg      <= neg_next;
        mag_reg      <= mag_next;
        plo_reg      <= plo_next;
        phi_reg      <= phi_next;
        y_reg        <= y_next;
        rem_reg      <= rem_next;
        q_reg        <= q_next;
        ch_reg       <= ch_next;
        res_der_reg  <= res_der_next;
        res_clip_reg <= res_clip_next;
        for (int k = 0; k < WIN_LEN; k++) win_reg[k] <= win_next[k];
        if (out_load) begin
            m_channel_out_reg <= ch_reg;
            m_derivative_reg  <= res_der_reg;
            m_clipped_reg     <= res_clip_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            win_mem[row_idx] <= new_row;
        end
        rd_row_q <= win_mem[row_idx];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < CHANNELS; c++) row_valid_reg[c] <= 1'b0;
            rd_vld_q <= 1'b0;
        end else begin
            if (mem_we) row_valid_reg[row_idx] <= 1'b1;
            rd_vld_q <= row_valid_reg[row_idx];
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_channel_out = m_channel_out_reg;
    assign m_derivative  = m_derivative_reg;
    assign m_clipped     = m_clipped_reg;

    a_pop_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head.valid)
        else $error("pop without a queued item");

    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIX) |-> (rem_reg < REM_LIMIT))
        else $error("division remainder out of range");

    a_neg_clip: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_clipped_reg && m_derivative_reg[DATA_W-1])
            |-> (m_derivative_reg == NEG_SAT))
        else $error("negative clip not at the minimum");

endmodule

>>> test/backward_difference_derivative_unit_test.sv
// Testbench for backward_difference_derivative_unit: sample transfers in, checked derivatives out.
// Holds its own model of the per-channel windows and the register settings.
// Depends on bdd_pkg and the RTL of the unit only.
`timescale 1ns / 1ps

module backward_difference_derivative_unit_test;
    import bdd_pkg::*;

    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          SETTLE_CYCLES  = 64;
    localparam logic [79:0] FULL_DIVISOR   = 80'd3932160;
    localparam logic [79:0] HALF_DIVISOR   = 80'd1966080;
    localparam int          SEG_ITEMS      = 132;

    typedef struct {
        logic [CH_W-1:0]   channel;
        logic [DATA_W-1:0] derivative;
        logic              clipped;
    } deriv_result_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [CH_W-1:0]    s_channel;
    logic [DATA_W-1:0]  s_sample_value;
    logic               m_valid;
    logic               m_ready;
    logic [CH_W-1:0]    m_channel_out;
    logic [DATA_W-1:0]  m_derivative;
    logic               m_clipped;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    // backward difference coefficients, scaled by 60
    int bdf_coef [0:5][0:6] = '{
        '{60, -60, 0, 0, 0, 0, 0},
        '{90, -120, 30, 0, 0, 0, 0},
        '{110, -180, 90, -20, 0, 0, 0},
        '{125, -240, 180, -80, 15, 0, 0},
        '{137, -300, 300, -200, 75, -12, 0},
        '{147, -360, 450, -400, 225, -72, 10}
    };

    logic [DATA_W-1:0]  sample_hist [CHANNELS][WIN_LEN];
    logic [DATA_W-1:0]  walk_level [CHANNELS];
    logic [ORDER_W-1:0] model_order;
    logic [31:0]        model_inv_period;
    deriv_result_t      expected_derivatives [$];
    int                 mismatch_count;
    int                 send_idle_pct;
    int                 recv_idle_pct;
    int                 quiet_cycles;

    backward_difference_derivative_unit u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_channel      (s_channel),
        .s_sample_value (s_sample_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_channel_out  (m_channel_out),
        .m_derivative   (m_derivative),
        .m_clipped      (m_clipped),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #2 aclk = ~aclk;

    function automatic deriv_result_t predict_derivative(input logic [CH_W-1:0] ch,
                                                         input logic [DATA_W-1:0] smp);
        deriv_result_t r;
        int            ord;
        int            i;
        longint        acc;
        logic          neg;
        logic [63:0]   mag;
        logic [79:0]   q;
        r.channel    = ch;
        r.derivative = '0;
        r.clipped    = 1'b0;
        if (int'(ch) >= CHANNELS) return r;
        for (i = WIN_LEN - 1; i > 0; i--) sample_hist[ch][i] = sample_hist[ch][i-1];
        sample_hist[ch][0] = smp;
        ord = int'(model_order);
        if (ord < 1) ord = 1;
        if (ord > MAX_ORDER) ord = MAX_ORDER;
        acc = 0;
        for (i = 0; i <= ord; i++)
            acc += longint'(bdf_coef[ord-1][i]) * longint'($signed(sample_hist[ch][i]));
        neg = (acc < 0);
        mag = neg ? 64'(-acc) : 64'(acc);
        // round half away from zero on the magnitude
        q = ({16'd0, mag} * {48'd0, model_inv_period} + HALF_DIVISOR) / FULL_DIVISOR;
        if (neg) begin
            if (q > 80'h8000_0000) begin
                q = 80'h8000_0000;
                r.clipped = 1'b1;
            end
            r.derivative = 32'd0 - q[31:0];
        end else begin
            if (q > 80'h7fff_ffff) begin
                q = 80'h7fff_ffff;
                r.clipped = 1'b1;
            end
            r.derivative = q[31:0];
        end
        return r;
    endfunction

    task automatic write_register(input logic reg_idx, input logic [31:0] value);
        @(negedge aclk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {reg_idx, 2'b00};
        pwdata  = value;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        if (reg_idx == REG_DIFF_ORDER) model_order = value[ORDER_W-1:0];
        else model_inv_period = value;
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic send_sample(input logic [CH_W-1:0] ch, input logic [DATA_W-1:0] smp);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid        = 1'b1;
        s_channel      = ch;
        s_sample_value = smp;
        do @(posedge aclk); while (!s_ready);
        expected_derivatives.push_back(predict_derivative(ch, smp));
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        s_valid = 1'b0;
        while (expected_derivatives.size() != 0) @(posedge aclk);
    endtask

    task automatic test_reset_defaults();
        send_sample(3'd0, 32'h0001_0000);
        send_sample(3'd7, 32'hffff_ffff);
        send_sample(3'd0, 32'h0000_8000);
    endtask

    task automatic test_order_sweep();
        int ord;
        for (ord = 0; ord < 8; ord++) begin
            wait_idle();
            write_register(REG_DIFF_ORDER, 32'(ord));
            send_sample(3'd1, 32'(ord * ord) * 32'h0003_0000 - 32'h0004_0000);
        end
    endtask

    task automatic test_rounding_ties();
        wait_idle();
        write_register(REG_DIFF_ORDER, 32'd1);
        write_register(REG_INV_PERIOD, 32'd32768);
        send_sample(3'd2, 32'd1);
        send_sample(3'd2, 32'd0);
        send_sample(3'd2, 32'hffff_fffd);
    endtask

    task automatic test_saturation();
        wait_idle();
        write_register(REG_DIFF_ORDER, 32'd6);
        write_register(REG_INV_PERIOD, 32'hffff_ffff);
        send_sample(3'd3, 32'h7fff_ffff);
        send_sample(3'd3, 32'h8000_0000);
        send_sample(3'd3, 32'h7fff_ffff);
        send_sample(3'd3, 32'h8000_0000);
        wait_idle();
        write_register(REG_INV_PERIOD, 32'd0);
        send_sample(3'd3, 32'h7fff_ffff);
        send_sample(3'd4, 32'h0000_0000);
    endtask

    task automatic test_random_traffic(input int sender_pct, input int receiver_pct);
        int                seg;
        int                n;
        int                pick;
        int                span;
        logic [CH_W-1:0]   ch;
        logic [DATA_W-1:0] smp;
        logic [31:0]       inv;
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        for (seg = 0; seg < 4; seg++) begin
            wait_idle();
            pick = $urandom_range(4);
            case (pick)
                0: inv = 32'd0;
                1: inv = 32'hffff_ffff;
                2: inv = INV_RESET;
                3: inv = $urandom_range(32'h0010_0000);
                default: inv = $urandom;
            endcase
            write_register(REG_DIFF_ORDER, 32'($urandom_range(7)));
            write_register(REG_INV_PERIOD, inv);
            for (n = 0; n < SEG_ITEMS; n++) begin
                ch   = CH_W'($urandom_range(CHANNELS - 1));
                pick = $urandom_range(9);
                if (pick < 8) begin
                    // smooth trajectory with random step size
                    span = 1 << (8 * $urandom_range(1, 3));
                    walk_level[ch] = walk_level[ch] + 32'($urandom_range(2 * span) - span);
                    smp = walk_level[ch];
                end else if (pick == 8) begin
                    smp = $urandom;
                end else begin
                    case ($urandom_range(3))
                        0: smp = 32'h7fff_ffff;
                        1: smp = 32'h8000_0000;
                        2: smp = 32'h0000_0000;
                        default: smp = 32'hffff_ffff;
                    endcase
                end
                send_sample(ch, smp);
            end
        end
    endtask

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin : check_results
        deriv_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_derivatives.size() == 0) begin
                $error("unexpected result transfer: channel_out %0d derivative %h",
                       m_channel_out, m_derivative);
                mismatch_count++;
            end else begin
                want = expected_derivatives.pop_front();
                if (m_channel_out !== want.channel) begin
                    $error("channel_out expected %0d got %0d", want.channel, m_channel_out);
                    mismatch_count++;
                end
                if (m_derivative !== want.derivative) begin
                    $error("derivative expected %h got %h", want.derivative, m_derivative);
                    mismatch_count++;
                end
                if (m_clipped !== want.clipped) begin
                    $error("clipped expected %0d got %0d", want.clipped, m_clipped);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (psel && penable && pready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[backward_difference_derivative_unit] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : run_tests
        int c;
        int i;
        aclk           = 1'b0;
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_channel      = '0;
        s_sample_value = '0;
        m_ready        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        mismatch_count = 0;
        quiet_cycles   = 0;
        send_idle_pct  = 0;
        recv_idle_pct  = 0;
        model_order      = ORDER_RESET;
        model_inv_period = INV_RESET;
        for (c = 0; c < CHANNELS; c++) begin
            walk_level[c] = '0;
            for (i = 0; i < WIN_LEN; i++) sample_hist[c][i] = '0;
        end
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_reset_defaults();
        test_order_sweep();
        test_rounding_ties();
        test_saturation();
        test_random_traffic(31, 84);
        test_random_traffic(84, 31);
        test_random_traffic(0, 0);

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("[backward_difference_derivative_unit] OK");
        end else begin
            $display("[backward_difference_derivative_unit] ERROR");
        end
        $finish;
    end

endmodule
